>>> rtl/qs_pkg.sv
// qs_pkg: shared types and constants for the quaternion slerp pipeline.
// Word structs for both channels, fixed-point widths and the CORDIC arctangent table.
// No dependencies.
package qs_pkg;

    localparam int DATA_W  = 16;
    localparam int BLEND_W = 17;
    localparam int THR_W   = 11;
    localparam int CW      = 34;   // CORDIC x, y, z width

    localparam logic [28:0]        ONE_Q28   = 29'h1000_0000;
    localparam logic [16:0]        BLEND_ONE = 17'h1_0000;
    localparam logic [15:0]        Q_ONE     = 16'd16384;
    localparam logic [THR_W-1:0]   THR_RESET = 11'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] a_w;
        logic signed [DATA_W-1:0] a_x;
        logic signed [DATA_W-1:0] a_y;
        logic signed [DATA_W-1:0] a_z;
        logic signed [DATA_W-1:0] b_w;
        logic signed [DATA_W-1:0] b_x;
        logic signed [DATA_W-1:0] b_y;
        logic signed [DATA_W-1:0] b_z;
        logic [BLEND_W-1:0]       blend;
    } t_qs_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_w;
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic                     near_equal;
    } t_qs_out;

    // atan(2^-i), Q4.30 radians
    function automatic logic signed [CW-1:0] qs_atan(input int unsigned i);
        logic signed [CW-1:0] v;
        unique case (i)
            0:       v = 34'sh3243F6A8;
            1:       v = 34'sh1DAC6705;
            2:       v = 34'sh0FADBAFC;
            3:       v = 34'sh07F56EA6;
            4:       v = 34'sh03FEAB76;
            5:       v = 34'sh01FFD55B;
            6:       v = 34'sh00FFFAAA;
            7:       v = 34'sh007FFF55;
            8:       v = 34'sh003FFFEA;
            9:       v = 34'sh001FFFFD;
            10:      v = 34'sh000FFFFF;
            11:      v = 34'sh0007FFFF;
            12:      v = 34'sh0003FFFF;
            13:      v = 34'sh0001FFFF;
            14:      v = 34'sh0000FFFF;
            15:      v = 34'sh00007FFF;
            16:      v = 34'sh00003FFF;
            17:      v = 34'sh00001FFF;
            18:      v = 34'sh00000FFF;
            19:      v = 34'sh000007FF;
            20:      v = 34'sh000003FF;
            21:      v = 34'sh000001FF;
            22:      v = 34'sh000000FF;
            23:      v = 34'sh0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/qs_isqrt.sv
// qs_isqrt: pipelined integer square root, one result bit per stage.
// Carries a sideband word alongside. Depends on nothing.
module qs_isqrt #(
    parameter int IW = 57,
    parameter int PW = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic [IW-1:0]           i_val,
    input  logic [PW-1:0]           i_side,
    output logic                    o_vld,
    output logic [(IW+1)/2-1:0]     o_root,
    output logic [PW-1:0]           o_side
);
    localparam int RW = (IW + 1) / 2;
    localparam int TW = IW + 2;

    logic [TW-1:0] r_rem  [RW];
    logic [TW-1:0] r_root [RW];
    logic [PW-1:0] r_side [RW];
    logic          r_vld  [RW];

    for (genvar s = 0; s < RW; s++) begin : g_stg
        localparam int B = RW - 1 - s;
        logic [TW-1:0] rem_in;
        logic [TW-1:0] root_in;
        logic [TW-1:0] trial;
        logic [PW-1:0] side_in;
        logic          vld_in;

        if (s == 0) begin : g_first
            assign rem_in  = TW'(i_val);
            assign root_in = '0;
            assign side_in = i_side;
            assign vld_in  = i_vld;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign side_in = r_side[s-1];
            assign vld_in  = r_vld[s-1];
        end

        assign trial = (root_in << (B + 1)) | (TW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[s]  <= rem_in - trial;
                    r_root[s] <= root_in | (TW'(1) << B);
                end else begin
                    r_rem[s]  <= rem_in;
                    r_root[s] <= root_in;
                end
                r_side[s] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1][RW-1:0];
    assign o_side = r_side[RW-1];

endmodule

>>> rtl/qs_cordic.sv
// qs_cordic: pipelined CORDIC, one micro-rotation per stage, vectoring or rotation mode.
// Uses qs_pkg for widths and the arctangent table.
module qs_cordic #(
    parameter int STEPS  = 16,
    parameter bit VECTOR = 1'b0,
    parameter int PW     = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic signed [qs_pkg::CW-1:0] i_x,
    input  logic signed [qs_pkg::CW-1:0] i_y,
    input  logic signed [qs_pkg::CW-1:0] i_z,
    input  logic [PW-1:0]               i_side,
    output logic                        o_vld,
    output logic signed [qs_pkg::CW-1:0] o_x,
    output logic signed [qs_pkg::CW-1:0] o_y,
    output logic signed [qs_pkg::CW-1:0] o_z,
    output logic [PW-1:0]               o_side
);
    import qs_pkg::*;

    logic signed [CW-1:0] r_x [STEPS];
    logic signed [CW-1:0] r_y [STEPS];
    logic signed [CW-1:0] r_z [STEPS];
    logic [PW-1:0]        r_side [STEPS];
    logic                 r_vld [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_stg
        logic signed [CW-1:0] x_in, y_in, z_in, dx, dy, n_x, n_y, n_z;
        logic [PW-1:0]        side_in;
        logic                 vld_in;
        logic                 up;

        if (s == 0) begin : g_first
            assign x_in    = i_x;
            assign y_in    = i_y;
            assign z_in    = i_z;
            assign side_in = i_side;
            assign vld_in  = i_vld;
        end else begin : g_next
            assign x_in    = r_x[s-1];
            assign y_in    = r_y[s-1];
            assign z_in    = r_z[s-1];
            assign side_in = r_side[s-1];
            assign vld_in  = r_vld[s-1];
        end

        assign dx = y_in >>> s;
        assign dy = x_in >>> s;
        assign up = VECTOR ? !y_in[CW-1] : !z_in[CW-1];

        always_comb begin
            if (VECTOR) begin
                if (up) begin
                    n_x = x_in + dx;
                    n_y = y_in - dy;
                    n_z = z_in + qs_atan(s);
                end else begin
                    n_x = x_in - dx;
                    n_y = y_in + dy;
                    n_z = z_in - qs_atan(s);
                end
            end else begin
                if (up) begin
                    n_x = x_in - dx;
                    n_y = y_in + dy;
                    n_z = z_in - qs_atan(s);
                end else begin
                    n_x = x_in + dx;
                    n_y = y_in - dy;
                    n_z = z_in + qs_atan(s);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s]    <= n_x;
                r_y[s]    <= n_y;
                r_z[s]    <= n_z;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_x    = r_x[STEPS-1];
    assign o_y    = r_y[STEPS-1];
    assign o_z    = r_z[STEPS-1];
    assign o_side = r_side[STEPS-1];

endmodule

>>> rtl/qs_div.sv
// qs_div: pipelined restoring divider, one quotient bit per stage.
// Numerator must be below divisor << QB. Depends on nothing.
module qs_div #(
    parameter int NW = 44,
    parameter int DW = 31,
    parameter int QB = 15,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_side,
    output logic          o_vld,
    output logic [QB-1:0] o_quo,
    output logic [PW-1:0] o_side
);
    localparam int TW = (NW > DW + QB) ? NW : DW + QB;

    logic [TW-1:0] r_num  [QB];
    logic [DW-1:0] r_den  [QB];
    logic [QB-1:0] r_quo  [QB];
    logic [PW-1:0] r_side [QB];
    logic          r_vld  [QB];

    for (genvar s = 0; s < QB; s++) begin : g_stg
        localparam int J = QB - 1 - s;
        logic [TW-1:0] num_in, sub;
        logic [DW-1:0] den_in;
        logic [QB-1:0] quo_in;
        logic [PW-1:0] side_in;
        logic          vld_in;

        if (s == 0) begin : g_first
            assign num_in  = TW'(i_num);
            assign den_in  = i_den;
            assign quo_in  = '0;
            assign side_in = i_side;
            assign vld_in  = i_vld;
        end else begin : g_next
            assign num_in  = r_num[s-1];
            assign den_in  = r_den[s-1];
            assign quo_in  = r_quo[s-1];
            assign side_in = r_side[s-1];
            assign vld_in  = r_vld[s-1];
        end

        assign sub = TW'(den_in) << J;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (num_in >= sub) begin
                    r_num[s] <= num_in - sub;
                    r_quo[s] <= quo_in | (QB'(1) << J);
                end else begin
                    r_num[s] <= num_in;
                    r_quo[s] <= quo_in;
                end
                r_den[s]  <= den_in;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[QB-1];
    assign o_quo  = r_quo[QB-1];
    assign o_side = r_side[QB-1];

endmodule

>>> rtl/quaternion_slerp_top.sv
// quaternion_slerp_top: pipelined fixed-point quaternion slerp, normalized output.
// Uses qs_pkg, qs_isqrt, qs_cordic and qs_div.
//
//   channel | signals                                  | dir
//   cfg     | i_cfg_valid  o_cfg_ready  i_cfg_data     | in
//   in      | i_in_valid   o_in_stall   i_in           | in
//   out     | o_out_valid  i_out_stall  o_out          | out
//
// One word enters per cycle while the output is not stalled; each word passes through the
// two CORDIC chains, the two bit-per-stage square roots and the 15-stage divider.
// Synchronous active-low reset empties the pipeline and sets near_threshold to 2.
// A stalled output word freezes every stage; o_in_stall rises only then.
module quaternion_slerp_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [qs_pkg::THR_W-1:0]   i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  qs_pkg::t_qs_in             i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output qs_pkg::t_qs_out            o_out
);
    import qs_pkg::*;

    localparam int DOTW = 35;
    localparam int VW   = 46;
    localparam int UW   = 30;
    localparam logic signed [DOTW-1:0] ONE_D = 35'sd268435456;

    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][16:0] b;
        logic [16:0]      t;
        logic             near;
    } t_mid;

    typedef struct packed {
        logic [3:0][15:0] a;
        logic             near;
    } t_tail;

    typedef struct packed {
        logic [3:0]       neg;
        logic [3:0][15:0] a;
        logic             near;
        logic             lenz;
    } t_fin;

    logic en;
    assign en          = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    logic [THR_W-1:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // stage 1: component products
    logic [3:0][15:0] in_a, in_b;
    logic [16:0]      in_t;
    assign in_a = {i_in.a_z, i_in.a_y, i_in.a_x, i_in.a_w};
    assign in_b = {i_in.b_z, i_in.b_y, i_in.b_x, i_in.b_w};
    assign in_t = (i_in.blend > BLEND_ONE) ? BLEND_ONE : i_in.blend;

    logic               r1_vld;
    logic signed [31:0] r1_p [4];
    t_mid               r1_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r1_p[k]   <= $signed(in_a[k]) * $signed(in_b[k]);
                r1_m.a[k] <= in_a[k];
                r1_m.b[k] <= {in_b[k][15], in_b[k]};
            end
            r1_m.t    <= in_t;
            r1_m.near <= 1'b0;
        end
    end

    // stage 2: dot, near test, sign fold, cosine clamp
    logic signed [DOTW-1:0] dot, diff, adiff, adot;
    logic                   neg2, near2;
    logic [28:0]            c2;
    t_mid                   m2;

    always_comb begin
        dot   = DOTW'(r1_p[0]) + DOTW'(r1_p[1]) + DOTW'(r1_p[2]) + DOTW'(r1_p[3]);
        diff  = ONE_D - dot;
        adiff = diff[DOTW-1] ? -diff : diff;
        near2 = adiff < $signed({10'b0, r_thr, 14'b0});
        neg2  = dot[DOTW-1];
        adot  = neg2 ? -dot : dot;
        c2    = (adot > ONE_D) ? ONE_Q28 : adot[28:0];
        m2    = r1_m;
        m2.near = near2;
        for (int k = 0; k < 4; k++) begin
            m2.b[k] = neg2 ? 17'(-$signed(r1_m.b[k])) : r1_m.b[k];
        end
    end

    logic        r2_vld;
    logic [28:0] r2_c;
    t_mid        r2_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_c <= c2;
            r2_m <= m2;
        end
    end

    // stage 3: cosine squared
    logic        r3_vld;
    logic [57:0] r3_csq;
    logic [28:0] r3_c;
    t_mid        r3_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_csq <= r2_c * r2_c;
            r3_c   <= r2_c;
            r3_m   <= r2_m;
        end
    end

    // sine = sqrt(1 - c^2)
    logic [56:0]             rad;
    logic                    vld4;
    logic [28:0]             s4;
    logic [$bits(t_mid)+28:0] side4;
    t_mid                    m4;
    logic [28:0]             c4;

    assign rad = (57'(1) << 56) - r3_csq[56:0];

    qs_isqrt #(.IW(57), .PW($bits(t_mid) + 29)) u_sqrt_sin (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r3_vld),
        .i_val  (rad),
        .i_side ({r3_m, r3_c}),
        .o_vld  (vld4),
        .o_root (s4),
        .o_side (side4)
    );
    assign {m4, c4} = side4;

    // angle = atan2(s, c)
    logic                 vld5;
    logic signed [CW-1:0] z5;
    t_mid                 m5;

    qs_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1), .PW($bits(t_mid))) u_cordic_ang (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (vld4),
        .i_x    ($signed(CW'(c4))),
        .i_y    ($signed(CW'(s4))),
        .i_z    ('0),
        .i_side (m4),
        .o_vld  (vld5),
        .o_x    (),
        .o_y    (),
        .o_z    (z5),
        .o_side (m5)
    );

    // stage 6: angle * blend
    logic [CW-2:0] ang6;
    assign ang6 = z5[CW-1] ? '0 : z5[CW-2:0];

    logic          r6_vld;
    logic [49:0]   r6_prod;
    logic [CW-2:0] r6_ang;
    t_mid          r6_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= vld5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_prod <= ang6 * m5.t;
            r6_ang  <= ang6;
            r6_m    <= m5;
        end
    end

    // stage 7: split angle
    logic                 r7_vld;
    logic signed [CW-1:0] r7_th1, r7_th2;
    t_mid                 r7_m;
    logic [CW-1:0]        th2_7;
    assign th2_7 = CW'(r6_prod[49:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_th2 <= $signed(th2_7);
            r7_th1 <= $signed(CW'(r6_ang)) - $signed(th2_7);
            r7_m   <= r6_m;
        end
    end

    // weights
    logic                 vld8;
    logic signed [CW-1:0] w1, w2;
    t_mid                 m8;
    localparam logic signed [CW-1:0] X0 = $signed(CW'(ONE_Q28));

    qs_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0), .PW($bits(t_mid))) u_cordic_w1 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r7_vld),
        .i_x    (X0),
        .i_y    ('0),
        .i_z    (r7_th1),
        .i_side (r7_m),
        .o_vld  (vld8),
        .o_x    (),
        .o_y    (w1),
        .o_z    (),
        .o_side (m8)
    );

    qs_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0), .PW(1)) u_cordic_w2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r7_vld),
        .i_x    (X0),
        .i_y    ('0),
        .i_z    (r7_th2),
        .i_side (1'b0),
        .o_vld  (),
        .o_x    (),
        .o_y    (w2),
        .o_z    (),
        .o_side ()
    );

    // stage 8: weighted products
    logic signed [49:0] pa [4];
    logic signed [50:0] pb [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pa[k] = w1 * $signed(m8.a[k]);
            pb[k] = w2 * $signed(m8.b[k]);
        end
    end

    logic                 r8_vld;
    logic signed [VW-1:0] r8_pa [4];
    logic signed [VW-1:0] r8_pb [4];
    t_tail                r8_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (en) begin
            r8_vld <= vld8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r8_pa[k] <= pa[k][VW-1:0];
                r8_pb[k] <= pb[k][VW-1:0];
            end
            r8_t.a    <= m8.a;
            r8_t.near <= m8.near;
        end
    end

    // stage 9: v = w1*a + w2*b
    logic                 r9_vld;
    logic signed [VW-1:0] r9_v [4];
    t_tail                r9_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else if (en) begin
            r9_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r9_v[k] <= r8_pa[k] + r8_pb[k];
            end
            r9_t <= r8_t;
        end
    end

    // stage 10: pairwise max of magnitudes
    logic [VW-1:0] mag10 [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mag10[k] = r9_v[k][VW-1] ? VW'(-r9_v[k]) : VW'(r9_v[k]);
        end
    end

    logic                 r10_vld;
    logic [VW-1:0]        r10_m01, r10_m23;
    logic signed [VW-1:0] r10_v [4];
    t_tail                r10_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else if (en) begin
            r10_vld <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_m01 <= (mag10[0] > mag10[1]) ? mag10[0] : mag10[1];
            r10_m23 <= (mag10[2] > mag10[3]) ? mag10[2] : mag10[3];
            r10_v   <= r9_v;
            r10_t   <= r9_t;
        end
    end

    // stage 11: normalizing shift
    logic [VW-1:0] m11;
    logic [4:0]    sh11;
    always_comb begin
        m11  = (r10_m01 > r10_m23) ? r10_m01 : r10_m23;
        sh11 = '0;
        for (int j = 0; j <= VW - 29; j++) begin
            if ((m11 >> j) >= (VW'(1) << 29)) begin
                sh11 = 5'(j + 1);
            end
        end
    end

    logic                 r11_vld;
    logic [4:0]           r11_sh;
    logic signed [VW-1:0] r11_v [4];
    t_tail                r11_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_vld <= 1'b0;
        end else if (en) begin
            r11_vld <= r10_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_sh <= sh11;
            r11_v  <= r10_v;
            r11_t  <= r10_t;
        end
    end

    // stage 12: shift
    logic signed [VW-1:0] vs12 [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            vs12[k] = r11_v[k] >>> r11_sh;
        end
    end

    logic                 r12_vld;
    logic signed [UW-1:0] r12_u [4];
    t_tail                r12_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_vld <= 1'b0;
        end else if (en) begin
            r12_vld <= r11_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r12_u[k] <= vs12[k][UW-1:0];
            end
            r12_t <= r11_t;
        end
    end

    // stage 13: squares
    logic signed [59:0] sq13 [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sq13[k] = r12_u[k] * r12_u[k];
        end
    end

    logic                 r13_vld;
    logic [58:0]          r13_sq [4];
    logic signed [UW-1:0] r13_u [4];
    t_tail                r13_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r13_vld <= 1'b0;
        end else if (en) begin
            r13_vld <= r12_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r13_sq[k] <= sq13[k][58:0];
            end
            r13_u <= r12_u;
            r13_t <= r12_t;
        end
    end

    // stage 14/15: sum of squares
    logic                 r14_vld;
    logic [59:0]          r14_s01, r14_s23;
    logic signed [UW-1:0] r14_u [4];
    t_tail                r14_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r14_vld <= 1'b0;
        end else if (en) begin
            r14_vld <= r13_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r14_s01 <= 60'(r13_sq[0]) + 60'(r13_sq[1]);
            r14_s23 <= 60'(r13_sq[2]) + 60'(r13_sq[3]);
            r14_u   <= r13_u;
            r14_t   <= r13_t;
        end
    end

    logic                 r15_vld;
    logic [60:0]          r15_sum;
    logic [3:0][UW-1:0]   r15_u;
    t_tail                r15_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r15_vld <= 1'b0;
        end else if (en) begin
            r15_vld <= r14_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r15_sum <= 61'(r14_s01) + 61'(r14_s23);
            for (int k = 0; k < 4; k++) begin
                r15_u[k] <= r14_u[k];
            end
            r15_t <= r14_t;
        end
    end

    // vector length
    logic                          vld16;
    logic [30:0]                   len16;
    logic [4*UW+$bits(t_tail)-1:0] side16;
    logic [3:0][UW-1:0]            u16;
    t_tail                         t16;

    qs_isqrt #(.IW(61), .PW(4 * UW + $bits(t_tail))) u_sqrt_len (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r15_vld),
        .i_val  (r15_sum),
        .i_side ({r15_u, r15_t}),
        .o_vld  (vld16),
        .o_root (len16),
        .o_side (side16)
    );
    assign {u16, t16} = side16;

    // stage 16: rounded numerators
    logic [UW-1:0] mag16 [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mag16[k] = u16[k][UW-1] ? UW'(-$signed(u16[k])) : u16[k];
        end
    end

    logic        r16_vld;
    logic [43:0] r16_num [4];
    logic [30:0] r16_len;
    t_fin        r16_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r16_vld <= 1'b0;
        end else if (en) begin
            r16_vld <= vld16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r16_num[k]    <= {mag16[k], 14'b0} + 44'(len16[30:1]);
                r16_f.neg[k]  <= u16[k][UW-1];
            end
            r16_len    <= len16;
            r16_f.a    <= t16.a;
            r16_f.near <= t16.near;
            r16_f.lenz <= (len16 == '0);
        end
    end

    // divide
    logic [14:0] quo [4];
    logic        vld17;
    t_fin        f17;

    for (genvar k = 0; k < 4; k++) begin : g_div
        if (k == 0) begin : g_lead
            qs_div #(.NW(44), .DW(31), .QB(15), .PW($bits(t_fin))) u_div (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (en),
                .i_vld  (r16_vld),
                .i_num  (r16_num[k]),
                .i_den  (r16_len),
                .i_side (r16_f),
                .o_vld  (vld17),
                .o_quo  (quo[k]),
                .o_side (f17)
            );
        end else begin : g_lane
            qs_div #(.NW(44), .DW(31), .QB(15), .PW(1)) u_div (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (en),
                .i_vld  (r16_vld),
                .i_num  (r16_num[k]),
                .i_den  (r16_len),
                .i_side (1'b0),
                .o_vld  (),
                .o_quo  (quo[k]),
                .o_side ()
            );
        end
    end

    // output register
    logic [3:0][15:0] res;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [15:0] q;
            q = (16'(quo[k]) > Q_ONE) ? Q_ONE : 16'(quo[k]);
            if (f17.near || f17.lenz) begin
                res[k] = f17.a[k];
            end else begin
                res[k] = f17.neg[k] ? 16'(-$signed(q)) : q;
            end
        end
    end

    logic    r_out_vld;
    t_qs_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= vld17;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.out_w      <= $signed(res[0]);
            r_out.out_x      <= $signed(res[1]);
            r_out.out_y      <= $signed(res[2]);
            r_out.out_z      <= $signed(res[3]);
            r_out.near_equal <= f17.near;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

>>> rtl/qs_checker.sv
// qs_checker: port-level assertions for quaternion_slerp_top, bound to every instance.
// Uses qs_pkg for the word types.
module qs_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_cfg_valid,
    input logic                     o_cfg_ready,
    input logic [qs_pkg::THR_W-1:0] i_cfg_data,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input qs_pkg::t_qs_in           i_in,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input qs_pkg::t_qs_out          o_out
);
    import qs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("output word changed under stall");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled output word");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind quaternion_slerp_top qs_checker u_qs_checker (.*);
